@@ hw/rtl/mfcl_pkg.sv @@
// Package for the mesh face component labeler: sizes, opcodes, register indexes.
// No dependencies.
`timescale 1ns / 1ps
package mfcl_pkg;
   localparam int MaxFaces = 1024;
   localparam int IdxW = 11;
   localparam int AddrW = 10;
   localparam int SidW = 16;
   localparam int LabelW = 12;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_RUN = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   localparam logic CSR_TASK_MODE = 1'b0;
   localparam logic [1:0] MODE_REBUILD = 2'd1;
   localparam logic [1:0] MODE_FIXED = 2'd2;
   localparam logic signed [LabelW-1:0] LABEL_LAYER = -12'sd1;

   // Map a 1-based face index to a memory address (index 1 to 0, index 1024 to 1023).
   function automatic logic [AddrW-1:0] face_addr(input logic [IdxW-1:0] idx);
      face_addr = idx[AddrW-1:0] - 10'd1;
   endfunction
endpackage

@@ hw/rtl/mesh_face_component_labeler_top.sv @@
// Top level of the mesh face component labeler: face table, label and work memories,
// labeling sequencer. Depends on mfcl_pkg.
// A load or unused opcode raises its result word straight from the idle state, a read
// after S_READ_WAIT fetches the label; no new request is taken until the last word is taken.
// A run clears the labels of the faces in use, checks each seed candidate, pops each labeled
// face and checks its three neighbors, then marks the layer faces in mode 1.
// After reset the label memory is cleared with req_ready low;
// reset sets task_mode 1 and face_count 0.
`timescale 1ns / 1ps
module mesh_face_component_labeler_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_opcode,
   input  logic [10:0] req_face_index,
   input  logic [10:0] req_neighbor_a,
   input  logic [10:0] req_neighbor_b,
   input  logic [10:0] req_neighbor_c,
   input  logic [15:0] req_surface_id,
   input  logic req_qualifies_rebuild,
   input  logic req_qualifies_fixed,
   input  logic req_inside_layer,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [11:0] rsp_face_label,
   output logic [10:0] rsp_group_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [10:0] csr_data
);
   import mfcl_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_READ_WAIT, S_CLEAR, S_SEED_RD, S_SEED_CHK, S_POP_RD, S_POP_WAIT,
      S_NB_RD, S_NB_CHK, S_MARK_RD, S_MARK_WR, S_DONE
   } state_type;

   // memories
   logic [32:0] nbr_mem [MaxFaces];
   logic [18:0] attr_mem [MaxFaces];
   logic [LabelW-1:0] label_mem [MaxFaces];
   logic [IdxW-1:0] work_mem [MaxFaces];

   state_type state_ff;
   logic [1:0] mode_ff;
   logic [IdxW-1:0] count_ff, groups_ff, ptr_ff, head_ff, tail_ff, cur_ff;
   logic [SidW-1:0] sid_ff;
   logic [1:0] k_ff;
   logic rsp_valid_ff;
   logic signed [LabelW-1:0] rsp_label_ff;
   logic [IdxW-1:0] nb_ff;

   logic [32:0] nbr_q_ff;
   logic [18:0] attr_q_ff;
   logic [LabelW-1:0] label_q_ff;
   logic [IdxW-1:0] work_q_ff;

   // memory port controls
   logic [AddrW-1:0] nbr_ra, attr_ra, lab_addr, work_ra;
   logic lab_we;
   logic [LabelW-1:0] lab_wd;
   logic work_we;
   logic [AddrW-1:0] work_wa;
   logic [IdxW-1:0] work_wd;

   logic req_acc, qual, lab_zero;
   logic [IdxW-1:0] sel_nb;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_acc = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_face_label = rsp_label_ff;
   assign rsp_group_count = groups_ff;

   assign qual = (mode_ff == MODE_REBUILD) ? attr_q_ff[16] :
                 (mode_ff == MODE_FIXED) ? attr_q_ff[17] : 1'b0;
   assign lab_zero = (label_q_ff == '0);

   always_comb begin
      case (k_ff)
         2'd0: sel_nb = nbr_q_ff[10:0];
         2'd1: sel_nb = nbr_q_ff[21:11];
         default: sel_nb = nbr_q_ff[32:22];
      endcase
   end

   // address selection
   always_comb begin
      nbr_ra = face_addr(cur_ff);
      attr_ra = face_addr(ptr_ff);
      lab_addr = face_addr(ptr_ff);
      work_ra = head_ff[AddrW-1:0];
      lab_we = 1'b0;
      lab_wd = '0;
      work_we = 1'b0;
      work_wa = tail_ff[AddrW-1:0];
      work_wd = ptr_ff;
      case (state_ff)
         S_INIT: begin
            lab_we = 1'b1;
         end
         S_IDLE: begin
            lab_addr = face_addr(req_face_index);
         end
         S_CLEAR: begin
            lab_we = 1'b1;
         end
         S_SEED_CHK: begin
            work_wa = '0;
            if (lab_zero && qual) begin
               lab_we = 1'b1;
               lab_wd = {1'b0, groups_ff} + 12'd1;
               work_we = 1'b1;
            end
         end
         S_POP_WAIT: begin
            nbr_ra = face_addr(work_q_ff);
         end
         S_NB_RD: begin
            attr_ra = face_addr(sel_nb);
            lab_addr = face_addr(sel_nb);
         end
         S_NB_CHK: begin
            lab_addr = face_addr(nb_ff);
            work_wd = nb_ff;
            if (lab_zero && qual && attr_q_ff[15:0] == sid_ff) begin
               lab_we = 1'b1;
               lab_wd = {1'b0, groups_ff};
               work_we = 1'b1;
            end
         end
         S_MARK_WR: begin
            if (attr_q_ff[18]) begin
               lab_we = 1'b1;
               lab_wd = LABEL_LAYER;
            end
         end
         default: ;
      endcase
   end

   // memory storage
   always_ff @(posedge clock) begin
      if (req_acc && req_opcode == OP_LOAD && req_face_index >= 11'd1 &&
          req_face_index <= 11'(MaxFaces)) begin
         nbr_mem[face_addr(req_face_index)] <= {req_neighbor_c, req_neighbor_b, req_neighbor_a};
         attr_mem[face_addr(req_face_index)] <= {req_inside_layer, req_qualifies_fixed,
                                                  req_qualifies_rebuild, req_surface_id};
      end
      nbr_q_ff <= nbr_mem[nbr_ra];
      attr_q_ff <= attr_mem[attr_ra];
      if (lab_we) label_mem[lab_addr] <= lab_wd;
      label_q_ff <= label_mem[lab_addr];
      if (work_we) work_mem[work_wa] <= work_wd;
      work_q_ff <= work_mem[work_ra];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         mode_ff <= MODE_REBUILD;
         count_ff <= '0;
         groups_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ptr_ff <= 11'd1; head_ff <= '0; tail_ff <= '0; cur_ff <= '0; k_ff <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_TASK_MODE) mode_ff <= csr_data[1:0];
            else count_ff <= (csr_data > 11'(MaxFaces)) ? 11'(MaxFaces) : csr_data;
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            // zero every label once after reset
            S_INIT: begin
               if (ptr_ff == 11'(MaxFaces)) begin
                  ptr_ff <= 11'd1;
                  state_ff <= S_IDLE;
               end else ptr_ff <= ptr_ff + 11'd1;
            end
            S_IDLE: begin
               if (req_acc) begin
                  rsp_label_ff <= '0;
                  ptr_ff <= 11'd1;
                  case (req_opcode)
                     OP_READ: state_ff <= S_READ_WAIT;
                     OP_RUN: begin
                        groups_ff <= '0;
                        state_ff <= (count_ff == '0) ? S_DONE : S_CLEAR;
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
                  cur_ff <= req_face_index;
               end
            end
            S_READ_WAIT: begin
               if (cur_ff >= 11'd1 && cur_ff <= 11'(MaxFaces))
                  rsp_label_ff <= label_q_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_CLEAR: begin
               if (ptr_ff == count_ff) begin
                  ptr_ff <= 11'd1;
                  state_ff <= S_SEED_RD;
               end else ptr_ff <= ptr_ff + 11'd1;
            end
            S_SEED_RD: state_ff <= S_SEED_CHK;
            S_SEED_CHK: begin
               if (lab_zero && qual) begin
                  groups_ff <= groups_ff + 11'd1;
                  sid_ff <= attr_q_ff[15:0];
                  head_ff <= '0;
                  tail_ff <= 11'd1;
                  state_ff <= S_POP_RD;
               end else if (ptr_ff == count_ff) begin
                  ptr_ff <= 11'd1;
                  state_ff <= (mode_ff == MODE_REBUILD) ? S_MARK_RD : S_DONE;
               end else begin
                  ptr_ff <= ptr_ff + 11'd1;
                  state_ff <= S_SEED_RD;
               end
            end
            S_POP_RD: begin
               if (head_ff == tail_ff) begin
                  if (ptr_ff == count_ff) begin
                     ptr_ff <= 11'd1;
                     state_ff <= (mode_ff == MODE_REBUILD) ? S_MARK_RD : S_DONE;
                  end else begin
                     ptr_ff <= ptr_ff + 11'd1;
                     state_ff <= S_SEED_RD;
                  end
               end else state_ff <= S_POP_WAIT;
            end
            S_POP_WAIT: begin
               cur_ff <= work_q_ff;
               head_ff <= head_ff + 11'd1;
               k_ff <= '0;
               state_ff <= S_NB_RD;
            end
            S_NB_RD: begin
               // neighbor word for cur_ff is valid here (read issued in POP_WAIT)
               nb_ff <= sel_nb;
               if (sel_nb == '0 || sel_nb > count_ff) begin
                  if (k_ff == 2'd2) state_ff <= S_POP_RD;
                  else k_ff <= k_ff + 2'd1;
               end else state_ff <= S_NB_CHK;
            end
            S_NB_CHK: begin
               if (lab_zero && qual && attr_q_ff[15:0] == sid_ff) tail_ff <= tail_ff + 11'd1;
               if (k_ff == 2'd2) state_ff <= S_POP_RD;
               else begin
                  k_ff <= k_ff + 2'd1;
                  state_ff <= S_NB_RD;
               end
            end
            S_MARK_RD: state_ff <= S_MARK_WR;
            S_MARK_WR: begin
               if (ptr_ff == count_ff) state_ff <= S_DONE;
               else begin
                  ptr_ff <= ptr_ff + 11'd1;
                  state_ff <= S_MARK_RD;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // the work list never grows past MaxFaces entries
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= 11'(MaxFaces)) else $error("work list overflow");
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_WAIT) |-> (head_ff < tail_ff)) else $error("pop from empty list");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("accept while busy");
endmodule

@@ tb/mesh_face_component_labeler_top_test.sv @@
// Self-checking testbench for the mesh face component labeler: a directed table, then
// random load/run/read traffic checked against an in-bench labeling model.
// Depends on mfcl_pkg and mesh_face_component_labeler_top.
`timescale 1ns / 1ps
module mesh_face_component_labeler_top_test;
   import mfcl_pkg::*;

   localparam logic CSR_FACE_COUNT = 1'b1;
   localparam logic [1:0] MODE_UNUSED_LO = 2'd0;
   localparam logic [1:0] MODE_UNUSED_HI = 2'd3;
   localparam int CycleLimit = 1000000;
   localparam int HoldOffCycles = 400;

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type kind;
      opcode_type op;
      logic [IdxW-1:0] idx;
      logic [IdxW-1:0] nb_a, nb_b, nb_c;
      logic [SidW-1:0] sid;
      logic rebuild, fixed, layer;
      logic csr_idx;
      logic [IdxW-1:0] csr_val;
      bit typed;
      logic signed [LabelW-1:0] want_label;
      logic [IdxW-1:0] want_groups;
   } row_type;

   typedef struct {
      logic signed [LabelW-1:0] label;
      logic [IdxW-1:0] groups;
   } answer_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   logic [10:0] req_face_index, req_neighbor_a, req_neighbor_b, req_neighbor_c;
   logic [15:0] req_surface_id;
   logic req_qualifies_rebuild, req_qualifies_fixed, req_inside_layer;
   logic rsp_valid, rsp_ready;
   logic signed [11:0] rsp_face_label;
   logic [10:0] rsp_group_count;
   logic csr_valid, csr_ready, csr_index;
   logic [10:0] csr_data;

   mesh_face_component_labeler_top u_top (.*);

   // Labeling model state
   logic [IdxW-1:0] nb_tab [1:MaxFaces][3];
   logic [SidW-1:0] sid_tab [1:MaxFaces];
   logic [2:0] attr_tab [1:MaxFaces];   // {layer, fixed, rebuild}
   logic signed [LabelW-1:0] label_tab [1:MaxFaces];
   logic [IdxW-1:0] last_groups;
   logic [1:0] cur_mode;
   int cur_faces;

   answer_type pending_answers[$];
   row_type table_rows[$];
   int fails, results_seen, items_sent, runs_sent, cycles;
   bit no_idle, held_off;

   // Clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   function automatic bit face_qualifies(int f);
      if (cur_mode == MODE_REBUILD) return attr_tab[f][0];
      if (cur_mode == MODE_FIXED) return attr_tab[f][1];
      return 1'b0;
   endfunction

   // Clear, seed, breadth-first walk, then mark layer faces in rebuild mode
   task automatic label_components();
      int groups, f, nb;
      int walk[$];
      logic [SidW-1:0] seed_sid;
      groups = 0;
      for (f = 1; f <= cur_faces; f++) label_tab[f] = '0;
      for (int seed = 1; seed <= cur_faces; seed++) begin
         if (label_tab[seed] != 0 || !face_qualifies(seed)) continue;
         groups++;
         seed_sid = sid_tab[seed];
         label_tab[seed] = LabelW'(groups);
         walk = {seed};
         while (walk.size() > 0) begin
            f = walk.pop_front();
            for (int k = 0; k < 3; k++) begin
               nb = nb_tab[f][k];
               if (nb == 0 || nb > cur_faces) continue;
               if (label_tab[nb] == 0 && sid_tab[nb] == seed_sid && face_qualifies(nb)) begin
                  label_tab[nb] = LabelW'(groups);
                  walk.push_back(nb);
               end
            end
         end
      end
      last_groups = groups[IdxW-1:0];
      if (cur_mode == MODE_REBUILD)
         for (f = 1; f <= cur_faces; f++)
            if (attr_tab[f][2]) label_tab[f] = LABEL_LAYER;
   endtask

   // Advance the model by one accepted word and return its answer
   task automatic predict_word(input row_type r, output answer_type a);
      int i;
      i = r.idx;
      a.label = '0;
      case (r.op)
         OP_LOAD: begin
            if (i >= 1 && i <= MaxFaces) begin
               nb_tab[i][0] = r.nb_a;
               nb_tab[i][1] = r.nb_b;
               nb_tab[i][2] = r.nb_c;
               sid_tab[i] = r.sid;
               attr_tab[i] = {r.layer, r.fixed, r.rebuild};
            end
         end
         OP_RUN: label_components();
         OP_READ: begin
            if (i >= 1 && i <= MaxFaces) a.label = label_tab[i];
         end
         default: ;
      endcase
      a.groups = last_groups;
   endtask

   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one word, hold it until accepted, then idle for a random gap that may be empty
   task automatic send_word(input row_type r);
      answer_type a;
      int g;
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_face_index <= r.idx;
      req_neighbor_a <= r.nb_a;
      req_neighbor_b <= r.nb_b;
      req_neighbor_c <= r.nb_c;
      req_surface_id <= r.sid;
      req_qualifies_rebuild <= r.rebuild;
      req_qualifies_fixed <= r.fixed;
      req_inside_layer <= r.layer;
      do @(posedge clock); while (!req_ready);
      predict_word(r, a);
      if (r.typed) begin
         a.label = r.want_label;
         a.groups = r.want_groups;
      end
      pending_answers.push_back(a);
      items_sent++;
      if (r.op == OP_RUN) runs_sent++;
      g = gap_len();
      for (int n = 0; n < g; n++) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Drain, then write one register
   task automatic write_reg(input logic which, input logic [IdxW-1:0] value);
      int v;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (which == CSR_TASK_MODE) begin
         cur_mode = value[1:0];
      end else begin
         v = value;
         cur_faces = (v > MaxFaces) ? MaxFaces : v;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic row_type blank_row();
      row_type r;
      r.kind = ROW_ITEM;
      r.op = OP_NONE;
      r.idx = '0;
      r.nb_a = '0; r.nb_b = '0; r.nb_c = '0;
      r.sid = '0;
      r.rebuild = 1'b0; r.fixed = 1'b0; r.layer = 1'b0;
      r.csr_idx = 1'b0;
      r.csr_val = '0;
      r.typed = 1'b0;
      r.want_label = '0;
      r.want_groups = '0;
      return r;
   endfunction

   function automatic row_type make_item(opcode_type op, int idx);
      row_type r;
      r = blank_row();
      r.kind = ROW_ITEM;
      r.op = op;
      r.idx = IdxW'(idx);
      return r;
   endfunction

   function automatic row_type make_face(int idx, int na, int nb, int nc, int sid,
                                         int rb, int fx, int ly);
      row_type r;
      r = make_item(OP_LOAD, idx);
      r.nb_a = IdxW'(na); r.nb_b = IdxW'(nb); r.nb_c = IdxW'(nc);
      r.sid = SidW'(sid);
      r.rebuild = rb[0]; r.fixed = fx[0]; r.layer = ly[0];
      return r;
   endfunction

   function automatic row_type with_answer(row_type r, int lbl, int grp);
      r.typed = 1'b1;
      r.want_label = LabelW'(lbl);
      r.want_groups = IdxW'(grp);
      return r;
   endfunction

   function automatic row_type make_csr(logic which, int value);
      row_type r;
      r = blank_row();
      r.kind = ROW_CSR;
      r.csr_idx = which;
      r.csr_val = IdxW'(value);
      return r;
   endfunction

   // Random face with neighbors mostly inside the faces in use
   function automatic row_type random_face(int idx, int used);
      row_type r;
      int nbs[3];
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 9))
            0: nbs[k] = 0;
            1: nbs[k] = $urandom_range(0, 2047);
            default: nbs[k] = $urandom_range(0, used);
         endcase
      end
      r = make_face(idx, nbs[0], nbs[1], nbs[2],
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 2),
                    $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      return r;
   endfunction

   // Check each result word against the oldest answer
   task automatic report(input string what, input int got, input int want);
      fails++;
      if (fails <= 40) $display("mismatch on %s: got %0d, want %0d", what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         answer_type a;
         if (pending_answers.size() == 0) begin
            report("unexpected word", rsp_group_count, -1);
         end else begin
            a = pending_answers.pop_front();
            if (rsp_face_label !== a.label) report("face_label", rsp_face_label, a.label);
            if (rsp_group_count !== a.groups)
               report("group_count", rsp_group_count, a.groups);
         end
         results_seen++;
      end
   end

   // Result side: random stalls plus one long hold-off to back up the block
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && results_seen >= 60) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         stall = gap_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Main stimulus
   initial begin
      int used, pick, idx;
      row_type r;
      fails = 0; results_seen = 0; items_sent = 0; runs_sent = 0; cycles = 0;
      no_idle = 1'b0; held_off = 1'b0;
      cur_mode = MODE_REBUILD; cur_faces = 0; last_groups = '0;
      for (int f = 1; f <= MaxFaces; f++) label_tab[f] = '0;
      reset = 1'b1;
      req_valid = 1'b0; req_opcode = OP_NONE; req_face_index = '0;
      req_neighbor_a = '0; req_neighbor_b = '0; req_neighbor_c = '0;
      req_surface_id = '0; req_qualifies_rebuild = 1'b0; req_qualifies_fixed = 1'b0;
      req_inside_layer = 1'b0;
      csr_valid = 1'b0; csr_index = CSR_TASK_MODE; csr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: reset state, ignored indexes, a small hand-worked mesh
      table_rows.push_back(with_answer(make_item(OP_READ, 5), 0, 0));
      table_rows.push_back(with_answer(make_item(OP_RUN, 0), 0, 0));
      table_rows.push_back(with_answer(make_item(OP_NONE, 3), 0, 0));
      table_rows.push_back(with_answer(make_item(OP_READ, 0), 0, 0));
      table_rows.push_back(with_answer(make_item(OP_READ, 2047), 0, 0));
      table_rows.push_back(make_csr(CSR_FACE_COUNT, 4));
      table_rows.push_back(make_face(1, 2, 1024, 0, 16'hFFFF, 1, 1, 0));
      table_rows.push_back(make_face(2, 1, 3, 2047, 16'hFFFF, 1, 0, 1));
      table_rows.push_back(make_face(3, 2, 4, 0, 0, 1, 1, 0));
      table_rows.push_back(make_face(4, 3, 0, 0, 0, 0, 1, 0));
      table_rows.push_back(with_answer(make_face(0, 2047, 2047, 2047, 16'hFFFF, 1, 1, 1),
                                       0, 0));
      table_rows.push_back(with_answer(make_face(2047, 1, 1, 1, 0, 1, 1, 1), 0, 0));
      table_rows.push_back(with_answer(make_item(OP_RUN, 0), 0, 2));
      table_rows.push_back(with_answer(make_item(OP_READ, 1), 1, 2));
      table_rows.push_back(with_answer(make_item(OP_READ, 2), -1, 2));
      table_rows.push_back(with_answer(make_item(OP_READ, 3), 2, 2));
      table_rows.push_back(with_answer(make_item(OP_READ, 4), 0, 2));
      table_rows.push_back(make_csr(CSR_TASK_MODE, int'(MODE_FIXED)));
      table_rows.push_back(with_answer(make_item(OP_RUN, 0), 0, 2));
      table_rows.push_back(with_answer(make_item(OP_READ, 2), 0, 2));
      table_rows.push_back(with_answer(make_item(OP_READ, 4), 2, 2));
      table_rows.push_back(with_answer(make_item(OP_READ, 1024), 0, 2));
      table_rows.push_back(make_item(OP_NONE, 1));
      foreach (table_rows[i]) begin
         if (table_rows[i].kind == ROW_CSR)
            write_reg(table_rows[i].csr_idx, table_rows[i].csr_val);
         else
            send_word(table_rows[i]);
      end

      // Random phases: pick a setting, load every face in use, then mixed traffic
      for (int phase = 0; phase < 9; phase++) begin
         no_idle = (phase % 3 == 2);
         case ($urandom_range(0, 5))
            0: write_reg(CSR_TASK_MODE, IdxW'(MODE_UNUSED_LO));
            1: write_reg(CSR_TASK_MODE, IdxW'(MODE_UNUSED_HI));
            2, 3: write_reg(CSR_TASK_MODE, IdxW'(MODE_REBUILD));
            default: write_reg(CSR_TASK_MODE, IdxW'(MODE_FIXED));
         endcase
         write_reg(CSR_FACE_COUNT, IdxW'((phase == 4) ? 0 : $urandom_range(1, 24)));
         used = cur_faces;
         for (int f = 1; f <= used; f++) send_word(random_face(f, used));
         for (int n = 0; n < 30; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               case ($urandom_range(0, 5))
                  0: idx = 0;
                  1: idx = $urandom_range(1025, 2047);
                  2: idx = $urandom_range(1, MaxFaces);
                  default: idx = $urandom_range(1, (used > 0) ? used : 1);
               endcase
               send_word(random_face(idx, used));
            end else if (pick < 50) begin
               send_word(make_item(OP_RUN, $urandom_range(0, 2047)));
            end else if (pick < 95) begin
               idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                 : $urandom_range(0, used + 2);
               send_word(make_item(OP_READ, idx));
            end else begin
               r = random_face($urandom_range(0, 2047), used);
               r.op = OP_NONE;
               send_word(r);
            end
         end
      end

      // Saturated face count: an unused mode sweeps every slot and clears all labels
      no_idle = 1'b0;
      write_reg(CSR_TASK_MODE, IdxW'(MODE_UNUSED_LO));
      write_reg(CSR_FACE_COUNT, IdxW'(2047));
      send_word(make_item(OP_RUN, 0));
      for (int n = 0; n < 6; n++) send_word(make_item(OP_READ, $urandom_range(1, MaxFaces)));
      send_word(make_item(OP_READ, MaxFaces));

      // Drain and finish
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (20) @(posedge clock);
      $display("covered %0d words (%0d labeling runs), %0d results checked",
               items_sent, runs_sent, results_seen);
      $display("modes 0..3, face counts from 0 up to saturation, one long result hold-off");
      if (fails == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", fails);
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/mfcl_pkg.sv
hw/rtl/mesh_face_component_labeler_top.sv
tb/mesh_face_component_labeler_top_test.sv
